FILE: rtl/page_framebuffer_pixel_glyph_writer_core_defines.svh
// Assertion macros for the page frame store core.
// Expects signals named clk and rst in the including module's scope.
`ifndef PAGE_FRAMEBUFFER_PIXEL_GLYPH_WRITER_CORE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_PIXEL_GLYPH_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PFGW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFGW_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> nxt) else $error(msg);

`endif

FILE: rtl/pfgw_pkg.sv
// Shared types, codes and defaults for the page frame store core.
// No dependencies; imported by the lane and top level modules.
package pfgw_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 64;
  localparam int STORE_DEPTH        = 1024;
  localparam int LANES              = 8;

  localparam logic [2:0] KIND_PIXEL  = 3'd0;
  localparam logic [2:0] KIND_FILL   = 3'd1;
  localparam logic [2:0] KIND_CURSOR = 3'd2;
  localparam logic [2:0] KIND_GLYPH  = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam logic [1:0] REG_INVERT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [3:0] GLYPH_WIDTH_RESET  = 4'd7;
  localparam logic [6:0] GLYPH_HEIGHT_RESET = 7'd18;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       color;
    logic [7:0] glyph_bits;
    logic [5:0] glyph_row;
    logic [9:0] byte_address;
  } pfgw_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } pfgw_result_t;

  // Broadcast to all lanes: a run of up to eight columns on one pixel row.
  typedef struct packed {
    logic       wr;      // draw pixels
    logic       rd;      // read one byte
    logic [7:0] x0;      // leftmost column
    logic [7:0] y;       // pixel row (page in bits 5:3)
    logic [3:0] w;       // run length, 1..8
    logic [7:0] bits;    // bit w-1 is leftmost
    logic       color;   // color of a set bit, invert already applied
  } pfgw_cmd_t;

  typedef struct packed {
    logic issue;   // latch the broadcast command
    logic commit;  // write back the modified byte
    logic sweep;   // write every lane at the sweep address
    logic fill;    // sweep value: 1 white, 0 black
  } pfgw_ctl_t;

endpackage

FILE: rtl/pfgw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pfgw_lane.sv
// One column lane: owns the store bank for columns x with x % 8 == LANE.
// Depends on pfgw_pkg and pfgw_ram.
module pfgw_lane import pfgw_pkg::*; #(
  parameter int LANE       = 0,
  parameter int PAGE_COLS  = 16,
  parameter int BANK_DEPTH = 128,
  parameter int BANK_AW    = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  pfgw_ctl_t          ctl,
  input  pfgw_cmd_t          cmd,
  input  logic [BANK_AW-1:0] sweep_addr,
  output logic [7:0]         rdata
);

  localparam logic [2:0] LANE_ID = 3'(LANE);

  logic [2:0]         offs;
  logic               hit;
  logic [2:0]         bit_sel;
  logic [7:0]         col;
  logic [BANK_AW-1:0] addr_next;
  logic               pix_next;
  logic [7:0]         mask_next;

  logic               active;
  logic               write;
  logic [BANK_AW-1:0] addr;
  logic [7:0]         mask;
  logic               pix;

  logic               we;
  logic [BANK_AW-1:0] waddr;
  logic [7:0]         wdata;

  // Position of this lane's column within the run.
  always_comb begin
    offs      = LANE_ID - cmd.x0[2:0];
    hit       = ({1'b0, offs} < cmd.w) && (cmd.wr || cmd.rd);
    bit_sel   = 3'(cmd.w - 4'd1 - {1'b0, offs});
    col       = cmd.x0 + {5'd0, offs};
    addr_next = BANK_AW'(int'(cmd.y[5:3]) * PAGE_COLS + int'(col[7:3]));
    pix_next  = cmd.bits[bit_sel] ? cmd.color : ~cmd.color;
    mask_next = 8'd1 << cmd.y[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      write  <= 1'b0;
    end else if (ctl.issue) begin
      active <= hit;
      write  <= cmd.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      addr <= addr_next;
      mask <= mask_next;
      pix  <= pix_next;
    end
  end

  always_comb begin
    we    = ctl.sweep || (ctl.commit && active && write);
    waddr = ctl.sweep ? sweep_addr : addr;
    if (ctl.sweep) begin
      wdata = {8{ctl.fill}};
    end else if (pix) begin
      wdata = rdata | mask;
    end else begin
      wdata = rdata & ~mask;
    end
  end

  pfgw_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_bank (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

endmodule

FILE: rtl/page_framebuffer_pixel_glyph_writer_core.sv
// Channel  | Handshake                  | Word
// ---------+----------------------------+-------------------------------
// item     | item_valid / item_stall    | pfgw_item_t: one draw command
// result   | result_valid / result_stall| pfgw_result_t: read byte, status
// config   | APB write/read, pready = 1 | invert, glyph width, glyph height
//
// A pixel, cursor, glyph row or read word passes from accept through decode,
// bank read, modify and write back, then idle (by way of done while a result waits).
// A fill sweeps one bank row per cycle across all eight column banks.
// After reset the store is cleared the same way, with item_stall held high
// until the clear sweep has covered every bank row.
// The result register frees the input: a new word is taken while a result
// waits under result_stall; a second result then waits in the core.
// Depends on pfgw_pkg, pfgw_lane, pfgw_ram and the defines header.
`include "page_framebuffer_pixel_glyph_writer_core_defines.svh"

module page_framebuffer_pixel_glyph_writer_core import pfgw_pkg::*; #(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  pfgw_item_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output pfgw_result_t result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int PAGES      = (DISPLAY_HEIGHT + 7) / 8;
  localparam int PAGE_COLS  = (DISPLAY_WIDTH + 7) / 8;
  localparam int BANK_DEPTH = PAGES * PAGE_COLS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int USED_BYTES = DISPLAY_WIDTH * PAGES;
  localparam logic [BANK_AW-1:0] SWEEP_LAST = BANK_AW'(BANK_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_MOD   = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [BANK_AW-1:0] sweep_idx;
  pfgw_item_t         item_q;
  logic               fill_color;
  logic               rd_q;
  logic [2:0]         bank_q;
  pfgw_result_t       res_hold;

  logic               invert;
  logic [3:0]         glyph_width;
  logic [6:0]         glyph_height;
  logic [7:0]         cursor_col;
  logic [7:0]         cursor_row;

  logic [3:0]         w_eff;
  logic [6:0]         h_eff;
  logic               reject;
  logic               in_cell;
  logic               last_row;
  logic               pix_on;
  logic               addr_ok;
  logic [2:0]         read_page;
  logic [9:0]         page_base;
  logic [7:0]         read_col;
  logic               status_next;
  logic [7:0]         cursor_col_next;
  logic [7:0]         cursor_row_next;
  pfgw_cmd_t          cmd;
  pfgw_ctl_t          ctl;

  logic [7:0]         lane_rdata [LANES];
  logic [7:0]         merged;
  pfgw_result_t       res_mod;
  logic               out_free;
  logic               load;
  logic               sweeping;
  logic               cfg_write;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert       <= 1'b0;
      glyph_width  <= GLYPH_WIDTH_RESET;
      glyph_height <= GLYPH_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_INVERT: invert       <= pwdata[0];
        REG_WIDTH:  glyph_width  <= pwdata[3:0];
        REG_HEIGHT: glyph_height <= pwdata[6:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INVERT: prdata = 32'(invert);
      REG_WIDTH:  prdata = 32'(glyph_width);
      REG_HEIGHT: prdata = 32'(glyph_height);
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- decode
  always_comb begin
    if (glyph_width == 4'd0) begin
      w_eff = 4'd1;
    end else if (glyph_width > 4'd8) begin
      w_eff = 4'd8;
    end else begin
      w_eff = glyph_width;
    end
    h_eff = (glyph_height == 7'd0) ? 7'd1 : glyph_height;

    reject   = (9'(cursor_col) + 9'(w_eff) > 9'(DISPLAY_WIDTH)) ||
               (9'(cursor_row) + 9'(h_eff) > 9'(DISPLAY_HEIGHT));
    in_cell  = 7'(item_q.glyph_row) < h_eff;
    last_row = 7'(item_q.glyph_row) == (h_eff - 7'd1);
    pix_on   = (9'(item_q.pos_x) < 9'(DISPLAY_WIDTH)) &&
               (9'(item_q.pos_y) < 9'(DISPLAY_HEIGHT));
    addr_ok  = 11'(item_q.byte_address) < 11'(USED_BYTES);

    // Page of a read address: highest page whose base it reaches.
    read_page = 3'd0;
    for (int p = 1; p < 8; p++) begin
      if (p < PAGES && 11'(item_q.byte_address) >= 11'(p * DISPLAY_WIDTH)) begin
        read_page = 3'(p);
      end
    end
    page_base = 10'(int'(read_page) * DISPLAY_WIDTH);
    read_col  = 8'(item_q.byte_address - page_base);

    cmd             = '0;
    status_next     = 1'b0;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;

    unique case (item_q.kind)
      KIND_PIXEL: begin
        cmd.wr    = pix_on;
        cmd.x0    = item_q.pos_x;
        cmd.y     = item_q.pos_y;
        cmd.w     = 4'd1;
        cmd.bits  = 8'd1;
        cmd.color = item_q.color ^ invert;
      end
      KIND_CURSOR: begin
        cursor_col_next = item_q.pos_x;
        cursor_row_next = item_q.pos_y;
      end
      KIND_GLYPH: begin
        status_next = reject;
        cmd.wr      = !reject && in_cell;
        cmd.x0      = cursor_col;
        cmd.y       = cursor_row + {2'd0, item_q.glyph_row};
        cmd.w       = w_eff;
        cmd.bits    = item_q.glyph_bits;
        cmd.color   = item_q.color ^ invert;
        if (!reject && in_cell && last_row) begin
          cursor_col_next = cursor_col + {4'd0, w_eff} + 8'd1;
        end
      end
      KIND_READ: begin
        cmd.rd = addr_ok;
        cmd.x0 = read_col;
        cmd.y  = {2'd0, read_page, 3'd0};
        cmd.w  = 4'd1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control
  assign item_stall = (state != ST_IDLE);
  assign sweeping   = (state == ST_CLEAR) || (state == ST_FILL);
  assign out_free   = !result_valid || !result_stall;
  assign load       = ((state == ST_MOD) || (state == ST_DONE)) && out_free;

  always_comb begin
    ctl.issue  = (state == ST_PREP);
    ctl.commit = (state == ST_MOD);
    ctl.sweep  = sweeping;
    ctl.fill   = (state == ST_FILL) && fill_color;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (sweep_idx == SWEEP_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (item_valid) state_next = ST_PREP;
      ST_PREP:  state_next = (item_q.kind == KIND_FILL) ? ST_FILL : ST_READ;
      ST_READ:  state_next = ST_MOD;
      ST_MOD:   state_next = out_free ? ST_IDLE : ST_DONE;
      ST_FILL:  if (sweep_idx == SWEEP_LAST) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep_idx  <= '0;
      cursor_col <= 8'd0;
      cursor_row <= 8'd0;
      rd_q       <= 1'b0;
    end else begin
      state <= state_next;
      if (sweeping) begin
        sweep_idx <= (sweep_idx == SWEEP_LAST) ? '0 : sweep_idx + 1'b1;
      end
      if (state == ST_PREP) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
        rd_q       <= cmd.rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      item_q <= item;
    end
    if (state == ST_PREP) begin
      fill_color <= item_q.color;
      bank_q     <= cmd.x0[2:0];
      res_hold   <= '{read_data: 8'd0, status: status_next};
    end else if (state == ST_MOD) begin
      res_hold <= res_mod;
    end
  end

  // ---------------------------------------------------------------- lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pfgw_lane #(
      .LANE       (g),
      .PAGE_COLS  (PAGE_COLS),
      .BANK_DEPTH (BANK_DEPTH),
      .BANK_AW    (BANK_AW)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cmd        (cmd),
      .sweep_addr (sweep_idx),
      .rdata      (lane_rdata[g])
    );
  end

  // Merge: only the addressed bank answers a read.
  always_comb begin
    merged  = rd_q ? lane_rdata[bank_q] : 8'd0;
    res_mod = '{read_data: merged, status: res_hold.status};
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= (state == ST_MOD) ? res_mod : res_hold;
    end
  end

  // ---------------------------------------------------------------- checks
  `PFGW_ASSERT(a_result_source, $rose(result_valid) |-> $past(state == ST_MOD || state == ST_DONE), "result raised outside modify or done")
  `PFGW_ASSERT_NEXT(a_fill_exit, state == ST_FILL, state == ST_FILL || state == ST_DONE, "fill sweep left early")
  `PFGW_ASSERT(a_cursor_prep, !$past(rst) && !$stable(cursor_col) |-> $past(state == ST_PREP), "cursor moved outside decode")
  `PFGW_ASSERT(a_clear_step, !$past(rst) && $past(state == ST_CLEAR) && state == ST_CLEAR |-> sweep_idx == BANK_AW'($past(sweep_idx) + 1'b1), "clear sweep skipped a row")

endmodule

FILE: tb/glyph_store_checker.sv
`timescale 1ns / 100ps
// Checker for the page frame store core: watches the draw, result and APB ports.
// Keeps its own frame store and cursor, predicts each result word and compares it.
// Depends on pfgw_pkg.
module glyph_store_checker import pfgw_pkg::*; #(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_stall,
  input  pfgw_item_t   item,
  input  logic         result_valid,
  input  logic         result_stall,
  input  pfgw_result_t result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           pending,
  output int           failures,
  output int           results_checked
);

  localparam int USED_BYTES = DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8);

  logic [7:0]   frame_bytes [STORE_DEPTH];
  logic [7:0]   cursor_col;
  logic [7:0]   cursor_row;
  logic         invert_on;
  logic [3:0]   cell_width;
  logic [6:0]   cell_height;
  pfgw_result_t awaited_results [$];

  initial begin
    pending = 0;
    failures = 0;
    results_checked = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (failures < 40)
      $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    failures++;
  endtask

  function automatic void clear_model();
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    cursor_col  = 8'd0;
    cursor_row  = 8'd0;
    invert_on   = 1'b0;
    cell_width  = GLYPH_WIDTH_RESET;
    cell_height = GLYPH_HEIGHT_RESET;
  endfunction

  function automatic void plot(input int unsigned x, input int unsigned y, input logic c);
    int unsigned idx;
    if (x >= DISPLAY_WIDTH || y >= DISPLAY_HEIGHT) return;
    if (invert_on) c = ~c;
    idx = (y / 8) * DISPLAY_WIDTH + x;
    if (idx >= STORE_DEPTH) return;
    frame_bytes[idx][y % 8] = c;
  endfunction

  function automatic pfgw_result_t draw_and_read(input pfgw_item_t w);
    pfgw_result_t r;
    int unsigned  gw;
    int unsigned  gh;
    r = '0;
    case (w.kind)
      KIND_PIXEL: plot(w.pos_x, w.pos_y, w.color);
      KIND_FILL: begin
        for (int i = 0; i < USED_BYTES && i < STORE_DEPTH; i++)
          frame_bytes[i] = {8{w.color}};
      end
      KIND_CURSOR: begin
        cursor_col = w.pos_x;
        cursor_row = w.pos_y;
      end
      KIND_GLYPH: begin
        gw = (cell_width == 0) ? 1 : (cell_width > 8) ? 8 : cell_width;
        gh = (cell_height == 0) ? 1 : cell_height;
        // edge check comes first and holds the cursor
        if (cursor_col + gw > DISPLAY_WIDTH || cursor_row + gh > DISPLAY_HEIGHT) begin
          r.status = 1'b1;
        end else if (w.glyph_row < gh) begin
          for (int unsigned c = 0; c < gw; c++)
            plot(cursor_col + c, cursor_row + w.glyph_row,
                 w.glyph_bits[gw - 1 - c] ? w.color : ~w.color);
          if (w.glyph_row == gh - 1) cursor_col = 8'(cursor_col + gw + 1);
        end
      end
      KIND_READ: begin
        if (w.byte_address < USED_BYTES && w.byte_address < STORE_DEPTH)
          r.read_data = frame_bytes[w.byte_address];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pfgw_result_t want;
    if (rst) begin
      clear_model();
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_INVERT: invert_on   = pwdata[0];
          REG_WIDTH:  cell_width  = pwdata[3:0];
          REG_HEIGHT: cell_height = pwdata[6:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        results_checked++;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (result.read_data !== want.read_data)
            report_mismatch("read_data", result.read_data, want.read_data);
          if (result.status !== want.status)
            report_mismatch("status", result.status, want.status);
        end
      end
      if (item_valid && !item_stall)
        awaited_results.push_back(draw_and_read(item));
    end
    pending <= awaited_results.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the page frame store regression: clock, reset, draw words and APB writes.
// Instantiates the core and glyph_store_checker; depends on pfgw_pkg.
module testbench;
  import pfgw_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_WORDS = 1950;
  localparam int PHASES       = 7;
  localparam int DW           = DISPLAY_WIDTH_DEF;
  localparam int DH           = DISPLAY_HEIGHT_DEF;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         item_valid = 1'b0;
  logic         item_stall;
  pfgw_item_t   item = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  pfgw_result_t result;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int pending;
  int failures;
  int results_checked;
  int words_sent = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;

  // current register values, used only to shape the stimulus
  logic [3:0] cur_width  = GLYPH_WIDTH_RESET;
  logic [6:0] cur_height = GLYPH_HEIGHT_RESET;

  always #5 clk = ~clk;

  page_framebuffer_pixel_glyph_writer_core dut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  glyph_store_checker u_checker (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .pending, .failures, .results_checked
  );

  always @(posedge clk) begin
    result_stall <= !quiet && ($urandom_range(99) < 13);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("page_framebuffer_pixel_glyph_writer_core regression: fail");
      $finish;
    end
  end

  function automatic pfgw_item_t random_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(pfgw_item_t)-1:0];
  endfunction

  function automatic int eff_width();
    return (cur_width == 0) ? 1 : (cur_width > 8) ? 8 : cur_width;
  endfunction

  function automatic int eff_height();
    return (cur_height == 0) ? 1 : cur_height;
  endfunction

  task automatic send_word(input pfgw_item_t w);
    while (!quiet && $urandom_range(99) < 13) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (item_stall);
    words_sent++;
  endtask

  task automatic send_op(input logic [2:0] kind, input int x, input int y, input logic c,
                         input int bits, input int row, input int addr);
    pfgw_item_t w;
    w = random_word();
    w.kind = kind;
    w.pos_x = 8'(x);
    w.pos_y = 8'(y);
    w.color = c;
    w.glyph_bits = 8'(bits);
    w.glyph_row = 6'(row);
    w.byte_address = 10'(addr);
    send_word(w);
  endtask

  // drop valid and hold until every predicted word has come back
  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cell(input logic inv, input logic [3:0] gw, input logic [6:0] gh);
    write_reg(REG_INVERT, {31'd0, inv});
    write_reg(REG_WIDTH, {28'd0, gw});
    write_reg(REG_HEIGHT, {25'd0, gh});
    cur_width = gw;
    cur_height = gh;
  endtask

  task automatic send_character();
    pfgw_item_t w;
    int rows;
    logic c;
    rows = (eff_height() > 64) ? 64 : eff_height();
    c = 1'($urandom_range(1));
    for (int r = 0; r < rows; r++) begin
      w = random_word();
      w.kind = KIND_GLYPH;
      w.color = c;
      w.glyph_row = 6'(r);
      // break the sequence now and then
      if ($urandom_range(99) < 5) w.glyph_row = 6'($urandom_range(63));
      send_word(w);
    end
  endtask

  task automatic send_burst();
    pfgw_item_t w;
    int pick;
    pick = $urandom_range(99);
    w = random_word();
    if (pick < 35) begin
      send_character();
    end else if (pick < 45) begin
      w.kind = KIND_CURSOR;
      if ($urandom_range(99) < 80) begin
        w.pos_x = 8'($urandom_range(DW - eff_width()));
        w.pos_y = 8'((eff_height() <= DH) ? $urandom_range(DH - eff_height())
                                          : $urandom_range(DH));
      end
      send_word(w);
    end else if (pick < 70) begin
      w.kind = KIND_PIXEL;
      if ($urandom_range(99) < 85) begin
        w.pos_x = 8'($urandom_range(DW - 1));
        w.pos_y = 8'($urandom_range(DH - 1));
      end
      send_word(w);
    end else if (pick < 90) begin
      w.kind = KIND_READ;
      send_word(w);
    end else if (pick < 92) begin
      w.kind = KIND_FILL;
      send_word(w);
    end else if (pick < 95) begin
      w.kind = 3'($urandom_range(5, 7));
      send_word(w);
    end else begin
      w.kind = KIND_GLYPH;
      send_word(w);
    end
  endtask

  initial begin
    static logic       inv_tab [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    static logic [3:0] wid_tab [PHASES] = '{4'd7, 4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5};
    static logic [6:0] hgt_tab [PHASES] = '{7'd18, 7'd64, 7'd1, 7'd0, 7'd127, 7'd9, 7'd12};
    int phase_goal;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed words under reset register values
    send_op(KIND_READ, 0, 0, 0, 0, 0, 0);
    send_op(KIND_READ, 0, 0, 0, 0, 0, 1023);
    send_op(KIND_PIXEL, 0, 0, 1, 0, 0, 0);
    send_op(KIND_PIXEL, 127, 63, 1, 0, 0, 0);
    send_op(KIND_PIXEL, 128, 5, 1, 0, 0, 0);
    send_op(KIND_PIXEL, 5, 64, 1, 0, 0, 0);
    send_op(KIND_PIXEL, 255, 255, 1, 0, 0, 0);
    send_op(KIND_READ, 0, 0, 0, 0, 0, 0);
    send_op(KIND_READ, 0, 0, 0, 0, 0, 1023);
    send_op(KIND_FILL, 0, 0, 1, 0, 0, 0);
    send_op(KIND_READ, 0, 0, 0, 0, 0, 500);
    send_op(KIND_PIXEL, 9, 9, 0, 0, 0, 0);
    send_op(KIND_READ, 0, 0, 0, 0, 0, 128 + 9);
    send_op(KIND_FILL, 0, 0, 0, 0, 0, 0);
    send_op(KIND_CURSOR, 0, 0, 0, 0, 0, 0);
    send_op(KIND_GLYPH, 0, 0, 1, 8'hA5, 0, 0);
    send_op(KIND_GLYPH, 0, 0, 1, 8'hFF, 30, 0);
    send_op(KIND_READ, 0, 0, 0, 0, 0, 0);
    send_op(KIND_CURSOR, 122, 0, 0, 0, 0, 0);
    send_op(KIND_GLYPH, 0, 0, 1, 8'hFF, 0, 0);
    send_op(KIND_CURSOR, 121, 46, 0, 0, 0, 0);
    send_op(KIND_GLYPH, 0, 0, 0, 8'h55, 17, 0);
    send_op(KIND_GLYPH, 0, 0, 1, 8'h7F, 0, 0);
    send_op(KIND_READ, 0, 0, 0, 0, 0, 7 * 128 + 127);
    send_op(3'd5, 200, 200, 1, 8'hFF, 63, 1023);
    send_op(3'd7, 0, 0, 0, 0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        if (p == PHASES - 1)
          set_cell(1'($urandom_range(1)), 4'($urandom_range(15)),
                   7'($urandom_range(1, 40)));
        else
          set_cell(inv_tab[p], wid_tab[p], hgt_tab[p]);
      end
      quiet = (p == 2);
      phase_goal = words_sent + RANDOM_WORDS / PHASES;
      while (words_sent < phase_goal) send_burst();
    end
    quiet = 1'b0;

    wait_idle();
    repeat (16) @(posedge clk);
    $display("covered %0d draw words over %0d register settings, %0d result words checked",
             words_sent, PHASES, results_checked);
    $display("pixels, fills, cursor moves, glyph rows with edge rejects, reads, unused kinds");
    if (failures == 0 && pending == 0)
      $display("page_framebuffer_pixel_glyph_writer_core regression: pass");
    else
      $display("page_framebuffer_pixel_glyph_writer_core regression: fail");
    $finish;
  end

endmodule
